// ===== hdl/point_in_polygon_test_top_assert.svh =====
// Assertion macros for the point-in-polygon block checker.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef POINT_IN_POLYGON_TEST_TOP_ASSERT_SVH
`define POINT_IN_POLYGON_TEST_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define PIP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pip assertion failed");

// Next-cycle implication, disabled while in reset.
`define PIP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pip assertion failed");

`endif

// ===== hdl/pip_pkg.sv =====
// Shared types and constants of the point-in-polygon block.
// No dependencies; compile first after the assertion header.
package pip_pkg;

  localparam int IdxW   = 8;
  localparam int CntW   = 9;
  localparam int PAddrW = 3;
  localparam int PDataW = 32;

  localparam logic [CntW-1:0] SatCount = '1;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  localparam logic [PAddrW-3:0] RegVertexCount = '0;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  typedef struct packed {
    logic hit;
    logic busy;
  } edge_stat_t;

endpackage

// ===== hdl/pip_if.sv =====
// Valid/ready channel interfaces: command beats in, result beats out.
// Depends on pip_pkg.
interface pip_in_if #(
  parameter int CoordW = 16
) ();
  import pip_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [IdxW-1:0]          vertex_index;
  logic signed [CoordW-1:0] coord_x;
  logic signed [CoordW-1:0] coord_y;

  modport source (output valid, command, vertex_index, coord_x, coord_y, input ready);
  modport sink   (input valid, command, vertex_index, coord_x, coord_y, output ready);
  modport mon    (input valid, ready, command, vertex_index, coord_x, coord_y);
endinterface

interface pip_res_if ();
  import pip_pkg::*;

  logic            valid;
  logic            ready;
  logic            inside_res;
  logic [CntW-1:0] crossing_count;

  modport source (output valid, inside_res, crossing_count, input ready);
  modport sink   (input valid, inside_res, crossing_count, output ready);
  modport mon    (input valid, ready, inside_res, crossing_count);
endinterface

// ===== hdl/pip_vtx_mem.sv =====
// Vertex table: one write port, one read port, registered read data.
// No package dependency.
module pip_vtx_mem #(
  parameter int DEPTH = 256,
  parameter int DW    = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem_q [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/pip_edge_unit.sv =====
// Three-stage edge crossing test: orient and subtract, multiply, compare.
// Depends on pip_pkg.
module pip_edge_unit #(
  parameter int CW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] xa_i,
  input  logic signed [CW-1:0] ya_i,
  input  logic signed [CW-1:0] xb_i,
  input  logic signed [CW-1:0] yb_i,
  input  logic signed [CW-1:0] px_i,
  input  logic signed [CW-1:0] py_i,
  output pip_pkg::edge_stat_t  stat_o
);
  import pip_pkg::*;

  localparam int DW = CW + 1;
  localparam int PW = 2 * DW;

  logic                 swap;
  logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y;
  logic                 in_rng;
  logic signed [DW-1:0] a_d, b_d, c_d, e_d;

  logic                 v1_q, ok1_q;
  logic signed [DW-1:0] a1_q, b1_q, c1_q, e1_q;
  logic                 v2_q, ok2_q;
  logic signed [PW-1:0] pl_q, pr_q;
  logic                 v3_q, hit3_q;

  // Orient the edge upwards; a horizontal edge has an empty y range.
  assign swap   = ya_i > yb_i;
  assign lo_x   = swap ? xb_i : xa_i;
  assign lo_y   = swap ? yb_i : ya_i;
  assign hi_x   = swap ? xa_i : xb_i;
  assign hi_y   = swap ? ya_i : yb_i;
  assign in_rng = (py_i >= lo_y) && (py_i < hi_y);

  assign a_d = {py_i[CW-1], py_i} - {lo_y[CW-1], lo_y};
  assign b_d = {hi_x[CW-1], hi_x} - {lo_x[CW-1], lo_x};
  assign c_d = {px_i[CW-1], px_i} - {lo_x[CW-1], lo_x};
  assign e_d = {hi_y[CW-1], hi_y} - {lo_y[CW-1], lo_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      hit3_q <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      hit3_q <= v2_q && ok2_q && (pl_q > pr_q);
    end
  end

  always_ff @(posedge clk_i) begin
    ok1_q <= in_rng;
    a1_q  <= a_d;
    b1_q  <= b_d;
    c1_q  <= c_d;
    e1_q  <= e_d;
    ok2_q <= ok1_q;
    pl_q  <= a1_q * b1_q;
    pr_q  <= c1_q * e1_q;
  end

  assign stat_o.hit  = hit3_q;
  assign stat_o.busy = v1_q | v2_q | v3_q;

endmodule

// ===== hdl/point_in_polygon_test_top.sv =====
// Point-in-polygon test by ray casting: top level with sequencer and APB register.
// Depends on pip_pkg, pip_if, pip_vtx_mem and pip_edge_unit.
//
// Usage:
//   in_i carries command beats. A write beat (command 0) stores (coord_x, coord_y)
//   at vertex_index and returns nothing. A query beat
//   (command 1) casts a ray from (coord_x, coord_y) towards +x over the closed
//   polygon of vertex_count vertices and returns one beat on res_o with the
//   crossing count and its parity (inside_res).
//   A query with n vertices walks the table: it reads one vertex per cycle from
//   the single read port of the vertex table (n + 1 reads, vertex 0 is read
//   again to close the polygon), then the three-stage edge pipeline drains.
//   With vertex_count 0 the walk is skipped and the sequencer goes straight to
//   its done state. in_i.ready is low while a query runs.
//   The user writes vertex_count over APB at address 0 only while the block is idle;
//   the block does not enforce it. Values above MAX_VERTICES act as MAX_VERTICES.
//   Reset clears the register and all control state; the vertex table holds
//   garbage until written. A stalled res_o holds its beat; the block keeps
//   taking command beats and only holds a finished query until the beat leaves.
module point_in_polygon_test_top #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_WIDTH  = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  pip_in_if.sink                      in_i,
  pip_res_if.source                   res_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pip_pkg::PAddrW-1:0]  paddr,
  input  logic [pip_pkg::PDataW-1:0]  pwdata,
  output logic [pip_pkg::PDataW-1:0]  prdata,
  output logic                        pready
);
  import pip_pkg::*;

  localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int VW = 2 * COORD_WIDTH;

  // Register file
  logic [CntW-1:0] vcount_q;
  logic            cfg_wr;

  // Sequencer
  state_e          state_q, state_d;
  logic [NW-1:0]   n_eff;
  logic [NW-1:0]   rd_cnt_q;
  logic            in_acc, is_query, issue, last_issue;
  logic            rvalid_q, rfirst_q;
  logic [NW-1:0]   cnt_q;
  logic [31:0]     cnt_ext;

  // Table access
  logic [31:0]     widx;
  logic            mem_we;
  logic [AW-1:0]   raddr;
  logic [VW-1:0]   rdata;
  logic [VW-1:0]   prev_q;

  logic signed [COORD_WIDTH-1:0] px_q, py_q;
  edge_stat_t                    estat;

  // Result register
  logic            res_valid_q, res_inside_q, res_load;
  logic [CntW-1:0] res_count_q;

  // APB: single register, zero-wait.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[PAddrW-1:2] == RegVertexCount);
  assign prdata = (paddr[PAddrW-1:2] == RegVertexCount) ? PDataW'(vcount_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (cfg_wr) begin
      vcount_q <= pwdata[CntW-1:0];
    end
  end

  // Clamp the vertex count to the table depth.
  assign n_eff = (32'(vcount_q) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount_q);

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_acc     = in_i.valid & in_i.ready;
  assign is_query   = (in_i.command == CmdQuery);

  // Vertex writes go straight into the table; out-of-range slots drop.
  assign widx   = 32'(in_i.vertex_index);
  assign mem_we = in_acc && (in_i.command == CmdWrite) && (widx < MAX_VERTICES);

  // Walk reads 0..n-1, then 0 again for the closing edge.
  assign issue      = (state_q == ST_WALK);
  assign last_issue = (rd_cnt_q == n_eff);
  assign raddr      = last_issue ? '0 : rd_cnt_q[AW-1:0];

  pip_vtx_mem #(
    .DEPTH (MAX_VERTICES),
    .DW    (VW),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (widx[AW-1:0]),
    .wdata_i ({in_i.coord_x, in_i.coord_y}),
    .re_i    (issue),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pip_edge_unit #(
    .CW (COORD_WIDTH)
  ) u_edge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rvalid_q & ~rfirst_q),
    .xa_i    ($signed(prev_q[VW-1:COORD_WIDTH])),
    .ya_i    ($signed(prev_q[COORD_WIDTH-1:0])),
    .xb_i    ($signed(rdata[VW-1:COORD_WIDTH])),
    .yb_i    ($signed(rdata[COORD_WIDTH-1:0])),
    .px_i    (px_q),
    .py_i    (py_q),
    .stat_o  (estat)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          state_d = (n_eff == '0) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (last_issue) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        // Wait for the last read and the edge pipeline to empty.
        if (!rvalid_q && !estat.busy) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign res_load = (state_q == ST_DONE) && (!res_valid_q || res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      rvalid_q    <= 1'b0;
      rfirst_q    <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rvalid_q <= issue;
      rfirst_q <= issue && (rd_cnt_q == '0);
      if (in_acc && is_query) begin
        rd_cnt_q <= '0;
        cnt_q    <= '0;
      end else begin
        if (issue) rd_cnt_q <= rd_cnt_q + NW'(1);
        if (estat.hit) cnt_q <= cnt_q + NW'(1);
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc && is_query) begin
      px_q <= in_i.coord_x;
      py_q <= in_i.coord_y;
    end
    if (rvalid_q) prev_q <= rdata;
    if (res_load) begin
      res_inside_q <= cnt_q[0];
      res_count_q  <= (cnt_ext > 32'(SatCount)) ? SatCount : cnt_ext[CntW-1:0];
    end
  end

  assign cnt_ext = 32'(cnt_q);

  assign res_o.valid          = res_valid_q;
  assign res_o.inside_res     = res_inside_q;
  assign res_o.crossing_count = res_count_q;

endmodule

// ===== hdl/pip_checker.sv =====
// Port-level checker for the point-in-polygon block, bound to the top level.
// Depends on pip_pkg, pip_if and point_in_polygon_test_top_assert.svh.
`include "point_in_polygon_test_top_assert.svh"

module pip_checker (
  input logic       clk_i,
  input logic       rst_ni,
  pip_in_if.sink    in_i,
  pip_res_if.source res_o
);
  import pip_pkg::*;

  // A stalled result beat holds.
  `PIP_ASSERT_NEXT(a_res_hold, res_o.valid && !res_o.ready, res_o.valid && $stable(res_o.inside_res) && $stable(res_o.crossing_count))

  // Parity follows the count unless the count saturated.
  `PIP_ASSERT_NOW(a_parity, res_o.valid && (res_o.crossing_count != SatCount), res_o.inside_res == res_o.crossing_count[0])

  // An accepted query blocks further command beats.
  `PIP_ASSERT_NEXT(a_query_busy, in_i.valid && in_i.ready && (in_i.command == CmdQuery), !in_i.ready)

  // A new result only appears after the command side was held.
  `PIP_ASSERT_NOW(a_res_after_walk, $rose(res_o.valid), $past(!in_i.ready))

endmodule

bind point_in_polygon_test_top pip_checker u_pip_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .res_o  (res_o)
);
